FILE: sv/b64_pkg.sv
`timescale 1ns / 1ps
package b64_pkg;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET  = 1'd1;

    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    localparam logic [7:0] CH_PAD       = 8'h3D;  // '='
    localparam logic [7:0] CH_PLUS      = 8'h2B;  // '+'
    localparam logic [7:0] CH_SLASH     = 8'h2F;  // '/'
    localparam logic [7:0] CH_MINUS     = 8'h2D;  // '-'
    localparam logic [7:0] CH_UNDERLINE = 8'h5F;  // '_'

    // One unit of work for the output side: up to four results from one group of input items.
    typedef struct packed {
        logic        encode;    // 1: word is read as sextets, 0: word is read as bytes
        logic        alpha;     // URL-safe alphabet
        logic [23:0] word;
        logic [1:0]  last_idx;  // number of results minus one
        logic [2:0]  data_cnt;  // encode: characters before the pads
        logic        last;
        logic        err;
    } t_job;

    function automatic logic [7:0] char_of(input logic [5:0] v, input logic alpha);
        logic [7:0] r;
        if (v < 6'd26) begin
            r = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            r = 8'h61 + {2'b00, v - 6'd26};
        end else if (v < 6'd62) begin
            r = 8'h30 + {2'b00, v - 6'd52};
        end else if (v == 6'd62) begin
            r = alpha ? CH_MINUS : CH_PLUS;
        end else begin
            r = alpha ? CH_UNDERLINE : CH_SLASH;
        end
        return r;
    endfunction

    // Bit 6 set means the character is not in the selected alphabet.
    function automatic logic [6:0] sextet_of(input logic [7:0] c, input logic alpha);
        logic [6:0] r;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = 7'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r = 7'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r = 7'(c - 8'h30 + 8'd52);
        end else if (c == (alpha ? CH_MINUS : CH_PLUS)) begin
            r = 7'd62;
        end else if (c == (alpha ? CH_UNDERLINE : CH_SLASH)) begin
            r = 7'd63;
        end else begin
            r = 7'd64;
        end
        return r;
    endfunction

endpackage

FILE: sv/b64_in_if.sv
`timescale 1ns / 1ps
interface b64_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

FILE: sv/b64_out_if.sv
`timescale 1ns / 1ps
interface b64_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic       decode_error;

    modport source (output valid, output out_byte, output out_last, output decode_error,
                    input ready);
    modport sink (input valid, input out_byte, input out_last, input decode_error,
                  output ready);
endinterface

FILE: sv/b64_front.sv
`timescale 1ns / 1ps
module b64_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [b64_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [b64_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                      i_accept,
    input  logic [7:0]                i_byte,
    input  logic                      i_last,
    output logic                      o_push,
    output b64_pkg::t_job             o_job
);
    import b64_pkg::*;

    logic        r_dir;
    logic        r_alpha;
    logic [1:0]  r_gp;
    logic [17:0] r_held;
    logic [1:0]  r_pad;
    logic        r_err;
    logic [1:0]  n_gp;
    logic [17:0] n_held;
    logic [1:0]  n_pad;
    logic        n_err;

    always_comb begin
        logic [6:0] sx;
        logic       emitted;
        logic [1:0] gp_inc;
        n_gp    = r_gp;
        n_held  = r_held;
        n_pad   = r_pad;
        n_err   = r_err;
        o_push  = 1'b0;
        o_job   = '0;
        o_job.alpha = r_alpha;
        sx      = '0;
        emitted = 1'b0;
        gp_inc  = r_gp + 2'd1;
        if (i_accept) begin
            if (r_dir == DIR_ENCODE) begin
                o_job.encode   = 1'b1;
                o_job.last_idx = 2'd3;
                if (r_gp == 2'd2) begin
                    o_job.word     = {r_held[15:0], i_byte};
                    o_job.data_cnt = 3'd4;
                    o_job.last     = i_last;
                    o_push         = 1'b1;
                    n_gp           = '0;
                    n_held         = '0;
                end else begin
                    n_held = {2'b00, r_held[7:0], i_byte};
                    n_gp   = gp_inc;
                    if (i_last) begin
                        // Partial group: two or three characters, then pads.
                        if (gp_inc == 2'd1) begin
                            o_job.word     = {i_byte, 16'h0000};
                            o_job.data_cnt = 3'd2;
                        end else begin
                            o_job.word     = {r_held[7:0], i_byte, 8'h00};
                            o_job.data_cnt = 3'd3;
                        end
                        o_job.last = 1'b1;
                        o_push     = 1'b1;
                    end
                end
                if (i_last) begin
                    n_gp   = '0;
                    n_held = '0;
                    n_pad  = '0;
                    n_err  = 1'b0;
                end
            end else begin
                if (!n_err) begin
                    if (i_byte == CH_PAD) begin
                        if (r_gp < 2'd2) begin
                            n_err = 1'b1;
                        end else begin
                            n_pad = r_pad + 2'd1;
                        end
                    end else begin
                        sx = sextet_of(i_byte, r_alpha);
                        if (sx[6] || r_pad != 2'd0) begin
                            n_err = 1'b1;
                        end
                    end
                end
                if (!n_err) begin
                    if (r_gp == 2'd3) begin
                        o_job.word = {r_held, sx[5:0]};
                        if (n_pad != 2'd0 && !i_last) begin
                            // A padded group must close the message.
                            n_err = 1'b1;
                        end else begin
                            emitted        = 1'b1;
                            o_job.last_idx = 2'd2 - n_pad;
                        end
                        n_gp   = '0;
                        n_held = '0;
                        n_pad  = '0;
                    end else begin
                        n_held = {r_held[11:0], sx[5:0]};
                        n_gp   = gp_inc;
                    end
                end
                o_push = emitted;
                if (i_last) begin
                    o_push = 1'b1;
                    if (n_err || n_gp != 2'd0 || !emitted) begin
                        o_job.word     = '0;
                        o_job.last_idx = 2'd0;
                        o_job.err      = 1'b1;
                    end
                    o_job.last = 1'b1;
                    n_gp   = '0;
                    n_held = '0;
                    n_pad  = '0;
                    n_err  = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir   <= DIR_ENCODE;
            r_alpha <= 1'b0;
            r_gp    <= '0;
            r_held  <= '0;
            r_pad   <= '0;
            r_err   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DIRECTION: begin
                    r_dir  <= i_cfg_data[0];
                    r_gp   <= '0;
                    r_held <= '0;
                    r_pad  <= '0;
                    r_err  <= 1'b0;
                end
                CFG_ALPHABET: begin
                    r_alpha <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end else begin
            r_gp   <= n_gp;
            r_held <= n_held;
            r_pad  <= n_pad;
            r_err  <= n_err;
        end
    end

endmodule

FILE: sv/b64_queue.sv
`timescale 1ns / 1ps
module b64_queue #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  b64_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output b64_pkg::t_job o_job
);
    import b64_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: sv/b64_back.sv
`timescale 1ns / 1ps
module b64_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  b64_pkg::t_job i_job,
    output logic          o_pop,
    b64_out_if.source     o_out
);
    import b64_pkg::*;

    logic [1:0] r_idx;
    logic       r_ov;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_derr;
    logic       emit;
    logic       final_res;
    logic [5:0] sext;
    logic [7:0] dbyte;
    logic [7:0] n_byte;

    assign emit      = i_valid && (!r_ov || o_out.ready);
    assign final_res = (r_idx == i_job.last_idx);
    assign o_pop     = emit && final_res;

    always_comb begin
        unique case (r_idx)
            2'd0: begin
                sext  = i_job.word[23:18];
                dbyte = i_job.word[23:16];
            end
            2'd1: begin
                sext  = i_job.word[17:12];
                dbyte = i_job.word[15:8];
            end
            2'd2: begin
                sext  = i_job.word[11:6];
                dbyte = i_job.word[7:0];
            end
            default: begin
                sext  = i_job.word[5:0];
                dbyte = 8'h00;
            end
        endcase
        if (i_job.encode) begin
            n_byte = ({1'b0, r_idx} < i_job.data_cnt) ? char_of(sext, i_job.alpha) : CH_PAD;
        end else begin
            n_byte = dbyte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (emit) begin
                r_ov  <= 1'b1;
                r_idx <= final_res ? 2'd0 : r_idx + 2'd1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte <= n_byte;
            r_last <= i_job.last && final_res;
            r_derr <= i_job.err;
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.out_byte     = r_byte;
    assign o_out.out_last     = r_last;
    assign o_out.decode_error = r_derr;

endmodule

FILE: sv/base64_codec_core.sv
`timescale 1ns / 1ps
// Streaming Base64 encoder/decoder, one byte per item in and one byte per result out.
// The front stage takes an input item when it is offered while the queue has room, and
// writes any job it causes into a job queue of QUEUE_DEPTH entries; the output stage
// turns each job into one to four results, one per cycle while the consumer is ready,
// through a registered output. Input is accepted every cycle while the queue has room,
// so with a ready consumer decoding sustains one item per cycle, and encoding is held
// back by the single-result register: four results per three items. The first result
// of an item passes the job queue and the output register, if the output stage is idle.
// After a decode error the message gives one result with decode_error and out_last set;
// results already delivered for that message should be discarded by the consumer.
// Registers: index 0 selects direction (0 encode, 1 decode, writing it clears the
// message state), index 1 selects the URL-safe alphabet; write only while idle.
module base64_codec_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [b64_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [b64_pkg::CFG_DATA_W-1:0] i_cfg_data,
    b64_in_if.sink                         i_in,
    b64_out_if.source                      o_out
);
    import b64_pkg::*;

    logic full;
    logic accept;
    logic push;
    logic pop;
    logic q_valid;
    t_job front_job;
    t_job head_job;

    assign i_in.ready = !full;
    assign accept     = i_in.valid && !full;

    b64_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_byte     (i_in.in_byte),
        .i_last     (i_in.in_last),
        .o_push     (push),
        .o_job      (front_job)
    );

    b64_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    b64_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_job   (head_job),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

FILE: sv/b64_checker.sv
`timescale 1ns / 1ps
module b64_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_cfg_we,
    input logic [b64_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input logic [b64_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [7:0]                     i_out_byte,
    input logic                           i_out_last,
    input logic                           i_out_error
);
    import b64_pkg::*;

    logic r_dir;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= DIR_ENCODE;
        end else if (i_cfg_we && i_cfg_idx == CFG_DIRECTION) begin
            r_dir <= i_cfg_data[0];
        end
    end

    // A result that is not taken stays on the port unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_byte) && $stable(i_out_last)
            && $stable(i_out_error))
        else $error("output item changed while stalled");

    // The error result closes its message and carries a zero byte.
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_error |-> i_out_last && i_out_byte == 8'h00)
        else $error("error result malformed");

    // Encoding never reports a decode error.
    a_enc_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_dir == DIR_ENCODE |-> !i_out_error)
        else $error("decode error while encoding");

    // Reset empties the output register.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

endmodule

bind base64_codec_core b64_checker u_b64_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_idx   (i_cfg_idx),
    .i_cfg_data  (i_cfg_data),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.out_last),
    .i_out_error (o_out.decode_error)
);

FILE: verif/base64_codec_core_test.sv
`timescale 1ns / 1ps
module base64_codec_core_test;
    import b64_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       err;
    } t_codec_out;

    typedef logic [7:0] t_octet_q[$];

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;

    b64_in_if  in_ch();
    b64_out_if out_ch();

    base64_codec_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    function automatic logic [7:0] sextet_char(input logic [5:0] v, input logic url);
        string letters;
        letters = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789";
        if (v == 6'd62) begin
            return url ? CH_MINUS : CH_PLUS;
        end
        if (v == 6'd63) begin
            return url ? CH_UNDERLINE : CH_SLASH;
        end
        return letters[v];
    endfunction

    // Bit 6 set means the character is outside the selected alphabet.
    function automatic logic [6:0] char_sextet(input logic [7:0] c, input logic url);
        for (int k = 0; k < 64; k++) begin
            if (sextet_char(6'(k), url) == c) begin
                return 7'(k);
            end
        end
        return 7'd64;
    endfunction

    class base64_tracker;
        logic        dir;
        logic        url;
        logic [1:0]  grp;
        logic [1:0]  pads;
        logic [17:0] held;
        logic        bad;
        t_codec_out  step_q[$];
        t_codec_out  pending_bytes[$];
        int          errors;

        function new();
            dir = DIR_ENCODE;
            url = 1'b0;
            errors = 0;
            clear_message();
        endfunction

        function void clear_message();
            grp = 2'd0;
            pads = 2'd0;
            held = 18'd0;
            bad = 1'b0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_DIRECTION) begin
                dir = val[0];
                clear_message();
            end else if (idx == CFG_ALPHABET) begin
                url = val[0];
            end
        endfunction

        function void emit(logic [7:0] d);
            step_q.push_back('{data: d, last: 1'b0, err: 1'b0});
        endfunction

        function void absorb_byte(logic [7:0] b, logic last);
            logic [23:0] word;
            logic [6:0]  s;
            logic [5:0]  v;
            int          cnt;
            step_q.delete();
            if (dir == DIR_ENCODE) begin
                if (grp >= 2'd2) begin
                    word = {held[15:0], b};
                    for (int i = 0; i < 4; i++) begin
                        emit(sextet_char(word[23-6*i -: 6], url));
                    end
                    grp = 2'd0;
                    held = 18'd0;
                end else begin
                    held = {held[9:0], b};
                    grp++;
                end
                if (last) begin
                    if (grp != 2'd0) begin
                        word = (grp == 2'd1) ? {held[7:0], 16'h0} : {held[15:0], 8'h0};
                        for (int i = 0; i < 4; i++) begin
                            emit(i <= grp ? sextet_char(word[23-6*i -: 6], url) : CH_PAD);
                        end
                    end
                    step_q[step_q.size()-1].last = 1'b1;
                    clear_message();
                end
            end else begin
                if (!bad) begin
                    v = 6'd0;
                    if (b == CH_PAD) begin
                        if (grp < 2'd2) begin
                            bad = 1'b1;
                        end else begin
                            pads++;
                        end
                    end else begin
                        s = char_sextet(b, url);
                        v = s[5:0];
                        if (s[6] || pads != 2'd0) begin
                            bad = 1'b1;
                        end
                    end
                    if (!bad) begin
                        if (grp == 2'd3) begin
                            word = {held, v};
                            // A padded group is only legal as the final group.
                            if (pads != 2'd0 && !last) begin
                                bad = 1'b1;
                            end else begin
                                cnt = 3 - int'(pads);
                                for (int i = 0; i < cnt; i++) begin
                                    emit(word[23-8*i -: 8]);
                                end
                            end
                            grp = 2'd0;
                            held = 18'd0;
                            pads = 2'd0;
                        end else begin
                            held = {held[11:0], v};
                            grp++;
                        end
                    end
                end
                if (last) begin
                    if (bad || grp != 2'd0 || step_q.size() == 0) begin
                        step_q.delete();
                        step_q.push_back('{data: 8'h00, last: 1'b1, err: 1'b1});
                    end else begin
                        step_q[step_q.size()-1].last = 1'b1;
                    end
                    clear_message();
                end
            end
            foreach (step_q[i]) begin
                pending_bytes.push_back(step_q[i]);
            end
        endfunction

        function void match_output(logic [7:0] data, logic last, logic err);
            t_codec_out want;
            if (pending_bytes.size() == 0) begin
                $display("%0t: unexpected output: byte %02h last %0b error %0b",
                         $time, data, last, err);
                errors++;
                return;
            end
            want = pending_bytes.pop_front();
            if (data !== want.data) begin
                $display("%0t: out_byte expected %02h actual %02h", $time, want.data, data);
                errors++;
            end
            if (last !== want.last) begin
                $display("%0t: out_last expected %0b actual %0b", $time, want.last, last);
                errors++;
            end
            if (err !== want.err) begin
                $display("%0t: decode_error expected %0b actual %0b", $time, want.err, err);
                errors++;
            end
        endfunction
    endclass

    base64_tracker board = new();

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            board.match_output(out_ch.out_byte, out_ch.out_last, out_ch.decode_error);
        end
    end

    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("base64_codec_core_test failed");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.in_last <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        board.absorb_byte(b, last);
    endtask

    task automatic send_message(input t_octet_q msg);
        foreach (msg[i]) begin
            send_byte(msg[i], i == msg.size() - 1);
        end
    endtask

    // Drops valid and waits until every expected result is in, plus a margin.
    task automatic settle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (board.pending_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(val);
        @(posedge i_clk);
        board.set_register(idx, CFG_DATA_W'(val));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_octet_q random_bytes(input int len);
        t_octet_q t;
        for (int i = 0; i < len; i++) begin
            t.push_back(8'($urandom_range(255)));
        end
        return t;
    endfunction

    // Well-formed text with random content, which is then often broken on purpose.
    function automatic t_octet_q random_text(input logic url);
        t_octet_q t;
        int       groups;
        int       pads;
        int       pos;
        groups = $urandom_range(1, 3);
        for (int i = 0; i < 4 * groups; i++) begin
            t.push_back(sextet_char(6'($urandom_range(63)), url));
        end
        pads = $urandom_range(0, 2);
        if (pads >= 1) t[t.size()-1] = CH_PAD;
        if (pads == 2) t[t.size()-2] = CH_PAD;
        pos = $urandom_range(0, t.size() - 1);
        case ($urandom_range(0, 9))
            0: t[pos] = 8'($urandom_range(255));
            1: void'(t.pop_back());
            2: t[pos] = CH_PAD;
            3: begin
                if (groups > 1) begin
                    t[3] = CH_PAD;
                    if ($urandom_range(1)) t[2] = CH_PAD;
                end
            end
            4: t = random_bytes($urandom_range(1, 6));
            5: begin
                if (url) t[pos] = $urandom_range(1) ? CH_PLUS : CH_SLASH;
                else t[pos] = $urandom_range(1) ? CH_MINUS : CH_UNDERLINE;
            end
            default: ;
        endcase
        return t;
    endfunction

    initial begin
        t_octet_q msg;
        int       sent;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        in_ch.valid   = 1'b0;
        in_ch.in_byte = 8'h00;
        in_ch.in_last = 1'b0;
        send_idle_pct = 36;
        recv_idle_pct = 58;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Encoding, standard alphabet: a full group with both specials, then
        // single-byte and two-byte tails that need two pads and one pad.
        msg = {8'hFB, 8'hEF, 8'hFF};
        send_message(msg);
        msg = {8'h00};
        send_message(msg);
        msg = {8'hFF, 8'h00};
        send_message(msg);
        settle();
        write_reg(CFG_ALPHABET, 1'b1);
        msg = {8'hFB, 8'hFF, 8'hBF};
        send_message(msg);
        settle();
        write_reg(CFG_DIRECTION, DIR_DECODE);
        msg = {CH_MINUS, CH_UNDERLINE, 8'h39, 8'h7A};
        send_message(msg);
        settle();
        write_reg(CFG_ALPHABET, 1'b0);
        // Two pads with nonzero leftover bits that must be ignored.
        msg = {CH_PLUS, CH_SLASH, CH_PAD, CH_PAD};
        send_message(msg);
        // A pad at the start of a group.
        msg = {CH_PAD};
        send_message(msg);
        // A data character after a pad.
        msg = {8'h41, 8'h42, CH_PAD, 8'h43};
        send_message(msg);
        // Message ends in the middle of a group.
        msg = {8'h41, 8'h42};
        send_message(msg);
        msg = {8'hFF};
        send_message(msg);

        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin send_idle_pct = 36; recv_idle_pct = 58; end
                1: begin send_idle_pct = 58; recv_idle_pct = 36; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int cfg = 0; cfg < 4; cfg++) begin
                settle();
                write_reg(CFG_DIRECTION, cfg[1]);
                write_reg(CFG_ALPHABET, cfg[0]);
                sent = 0;
                while (sent < 36) begin
                    if (cfg[1] == DIR_ENCODE) begin
                        msg = random_bytes($urandom_range(1, 8));
                    end else begin
                        msg = random_text(cfg[0]);
                    end
                    send_message(msg);
                    sent += msg.size();
                end
            end
        end

        settle();
        repeat (20) @(posedge i_clk);
        if (board.errors == 0 && board.pending_bytes.size() == 0) begin
            $display("base64_codec_core_test passed");
        end else begin
            $display("base64_codec_core_test failed");
        end
        $finish;
    end
endmodule

FILE: filelist.f
sv/b64_pkg.sv
sv/b64_in_if.sv
sv/b64_out_if.sv
sv/b64_front.sv
sv/b64_queue.sv
sv/b64_back.sv
sv/base64_codec_core.sv
sv/b64_checker.sv
verif/base64_codec_core_test.sv
